@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;
    localparam int CELL_WIDTH      = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Action codes of an input request.
    localparam logic [1:0] ACT_CHAR      = 2'd0;
    localparam logic [1:0] ACT_BACKSPACE = 2'd1;
    localparam logic [1:0] ACT_CLEAR     = 2'd2;
    localparam logic [1:0] ACT_READ      = 2'd3;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam logic [7:0] TAB_STEP  = 8'd4;
    localparam logic [7:0] TAB_MASK  = ~8'd3;
    localparam logic [5:0] VTAB_STEP = 6'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_TAB,
        KIND_VTAB,
        KIND_BACKSPACE,
        KIND_CLEAR,
        KIND_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic [4:0] read_row;
        logic [6:0] read_col;
        logic       read_ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/text_console_writer_top.sv @@
// Text console writer: a ROWS x COLUMNS screen of character and attribute
// cells with a cursor.
// Input channel (in_valid, in_stall, in_data): one request per item, taken
// at an edge with in_valid high and in_stall low. Requests print or move by
// control character, backspace, clear the screen or read one cell.
// Output channel (out_valid, out_stall, out_data): exactly one result per
// request, in order: the cursor after the request and, for a read, the cell.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the
// attribute byte; it is always ready and should be written only while idle.
// An accepted request passes through the queue and the sequencer states
// IDLE, EXEC, READ_WAIT (only for an in-range read) and RESULT before
// out_valid is registered. The sequencer handles one request at a time; a
// scroll or a clear adds a sweep of the single screen memory, cell by cell.
// A two-entry request queue keeps taking items while the sequencer works
// or while a result waits under out_stall; in_stall rises when it is full.
// After reset all ROWS*COLUMNS cells (2000 by default) of the screen memory
// are swept to blanks with attribute 0x07, with in_stall held high.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tcw_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tcw_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import tcw_pkg::*;

    queue_status_t q_status;
    cmd_t          push_cmd, head_cmd;
    logic          push, pop, init_busy;

    assign cfg_ready = 1'b1;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_status  (q_status),
        .init_busy (init_busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .status    (q_status)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_head    (head_cmd),
        .pop       (pop),
        .init_busy (init_busy),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ rtl/tcw_ram.sv @@
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/tcw_front.sv @@
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tcw_pkg::in_item_t     in_data,
    input  tcw_pkg::queue_status_t q_status,
    input  logic                  init_busy,
    output logic                  push,
    output tcw_pkg::cmd_t         cmd
);
    import tcw_pkg::*;

    localparam logic [5:0] ROWS_W = 6'(ROWS);
    localparam logic [7:0] COLS_W = 8'(COLUMNS);

    assign in_stall = q_status.full || init_busy;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        cmd.ch       = in_data.char_code;
        cmd.read_row = in_data.read_row;
        cmd.read_col = in_data.read_col;
        cmd.read_ok  = ({1'b0, in_data.read_row} < ROWS_W) &&
                       ({1'b0, in_data.read_col} < COLS_W);
        case (in_data.action)
            ACT_CHAR:
            begin
                case (in_data.char_code)
                    CH_LF:   cmd.kind = KIND_NEWLINE;
                    CH_CR:   cmd.kind = KIND_RETURN;
                    CH_TAB:  cmd.kind = KIND_TAB;
                    CH_VT:   cmd.kind = KIND_VTAB;
                    default: cmd.kind = KIND_PRINT;
                endcase
            end
            ACT_BACKSPACE: cmd.kind = KIND_BACKSPACE;
            ACT_CLEAR:     cmd.kind = KIND_CLEAR;
            ACT_READ:      cmd.kind = KIND_READ;
            default:       cmd.kind = KIND_READ;
        endcase
    end

endmodule

@@ rtl/tcw_queue.sv @@
module tcw_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tcw_pkg::cmd_t          push_data,
    input  logic                   pop,
    output tcw_pkg::cmd_t          head,
    output tcw_pkg::queue_status_t status
);
    import tcw_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    cmd_t          entries_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/tcw_back.sv @@
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcw_pkg::queue_status_t q_status,
    input  tcw_pkg::cmd_t          q_head,
    output logic                   pop,
    output logic                   init_busy,
    input  logic                   cfg_valid,
    input  logic [7:0]             cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output tcw_pkg::out_item_t     out_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] MOVE_COUNT = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [7:0]    COLS_W     = 8'(COLUMNS);
    localparam logic [7:0]    COL_LAST   = 8'(COLUMNS - 1);
    localparam logic [5:0]    ROWS_W     = 6'(ROWS);
    localparam logic [5:0]    ROW_LAST   = 6'(ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ_WAIT,
        S_SCROLL,
        S_FILL,
        S_RESULT
    } state_t;

    state_t          state_reg, state_next;
    logic [6:0]      col_reg, col_next;
    logic [4:0]      row_reg, row_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      attr_reg, attr_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CELL_WIDTH-1:0] cell_reg, cell_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [CELL_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [AW-1:0]         cur_addr, read_addr;

    assign cur_addr  = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign read_addr = AW'(cmd_reg.read_row) * COLS_A + AW'(cmd_reg.read_col);

    assign init_busy = (state_reg == S_INIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tcw_ram #(
        .WIDTH (CELL_WIDTH),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        logic [7:0] col_w;
        logic [5:0] row_w;
        logic       scroll;

        col_w = {1'b0, col_reg};
        row_w = {1'b0, row_reg};
        scroll = 1'b0;

        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        cell_next      = cell_reg;
        attr_next      = cfg_valid ? cfg_data : attr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        ram_wdata      = {attr_reg, BLANK_CHAR};
        ram_re         = 1'b0;
        ram_raddr      = read_addr;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {RESET_ATTR, BLANK_CHAR};
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cell_next  = '0;
                state_next = S_RESULT;
                case (cmd_reg.kind)
                    KIND_PRINT:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = {attr_reg, cmd_reg.ch};
                        col_w     = col_w + 8'd1;
                    end
                    KIND_NEWLINE:
                    begin
                        col_w = '0;
                        row_w = row_w + 6'd1;
                    end
                    KIND_RETURN:
                    begin
                        col_w = '0;
                    end
                    KIND_TAB:
                    begin
                        col_w = (col_w + TAB_STEP) & TAB_MASK;
                    end
                    KIND_VTAB:
                    begin
                        row_w = row_w + VTAB_STEP;
                    end
                    KIND_BACKSPACE:
                    begin
                        // The previous cell is always one address below in
                        // row-major order, also across a row boundary.
                        ram_waddr = cur_addr - 1'b1;
                        ram_wdata = {attr_reg, CH_NUL};
                        if (col_reg != '0)
                        begin
                            ram_we = 1'b1;
                            col_w  = col_w - 8'd1;
                        end
                        else if (row_reg != '0)
                        begin
                            ram_we = 1'b1;
                            row_w  = row_w - 6'd1;
                            col_w  = COL_LAST;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        col_w      = '0;
                        row_w      = '0;
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end
                    KIND_READ:
                    begin
                        if (cmd_reg.read_ok)
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase

                if (col_w >= COLS_W)
                begin
                    col_w = '0;
                    row_w = row_w + 6'd1;
                end
                if (row_w >= ROWS_W)
                begin
                    row_w  = ROW_LAST;
                    scroll = 1'b1;
                end
                if (scroll)
                begin
                    cnt_next   = '0;
                    state_next = S_SCROLL;
                end
                col_next = col_w[6:0];
                row_next = row_w[4:0];
            end
            S_READ_WAIT:
            begin
                cell_next  = ram_rdata;
                state_next = S_RESULT;
            end
            S_SCROLL:
            begin
                // Reads run one cell ahead of the writes they feed.
                if (cnt_reg != MOVE_COUNT)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg + COLS_A;
                end
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == MOVE_COUNT)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FILL:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{cursor_col: col_reg,
                                       cursor_row: row_reg,
                                       cell_char:  cell_reg[7:0],
                                       cell_attr:  cell_reg[15:8]};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            attr_reg      <= RESET_ATTR;
            cmd_reg       <= '0;
            cell_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            attr_reg      <= attr_next;
            cmd_reg       <= cmd_next;
            cell_reg      <= cell_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

@@ rtl/tcw_checker.sv @@
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input tcw_pkg::out_item_t out_data
);
    import tcw_pkg::*;

    localparam logic [7:0] COLS_W = 8'(COLUMNS);
    localparam logic [5:0] ROWS_W = 6'(ROWS);

    logic [2:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result held under stall keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // The cursor reported is always on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_data.cursor_col} < COLS_W) &&
                      ({1'b0, out_data.cursor_row} < ROWS_W))
        else $error("cursor outside the screen");

    // Every result belongs to a request that was taken and not yet answered.
    a_result_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding request");

    // The screen sweep after reset holds off requests.
    a_init_stall: assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall)
        else $error("request accepted before the screen was initialized");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ dv/tb_text_console_writer_top.sv @@
`timescale 1ns / 100ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int COLS        = DEFAULT_COLUMNS;
    localparam int LINES       = DEFAULT_ROWS;
    localparam int CELLS       = COLS * LINES;
    localparam int SCRIPT_LEN  = 25;
    localparam int PHASE_ITEMS = 381;
    localparam int SETTLE_GAP  = 16;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } script_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    // Shadow copy of the console: screen image, cursor and attribute.
    logic [15:0] shadow_screen [CELLS];
    int          shadow_col;
    int          shadow_row;
    logic [7:0]  shadow_attr;

    out_item_t   cursor_reports [$];
    script_row_t script [SCRIPT_LEN];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int scrolls        = 0;
    int clears         = 0;
    int reads_in_range = 0;
    int attr_writes    = 0;

    text_console_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the shadow console and returns the report it yields.
    function automatic out_item_t console_apply(input in_item_t req);
        out_item_t res;
        logic [15:0] read_cell;
        res = '0;
        case (req.action)
            ACT_CHAR:
            begin
                case (req.char_code)
                    CH_LF:
                    begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                    CH_CR:  shadow_col = 0;
                    CH_TAB: shadow_col = (shadow_col + 4) & ~3;
                    CH_VT:  shadow_row += 3;
                    default:
                    begin
                        shadow_screen[shadow_row * COLS + shadow_col] =
                            {shadow_attr, req.char_code};
                        shadow_col++;
                    end
                endcase
                if (shadow_col >= COLS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // A row overflow scrolls exactly one line, however far it overshoots.
                if (shadow_row >= LINES)
                begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        shadow_screen[i] = shadow_screen[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        shadow_screen[i] = {shadow_attr, BLANK_CHAR};
                    shadow_row = LINES - 1;
                    scrolls++;
                end
            end
            ACT_BACKSPACE:
            begin
                if (shadow_col > 0 || shadow_row > 0)
                begin
                    if (shadow_col > 0)
                        shadow_col--;
                    else
                    begin
                        shadow_row--;
                        shadow_col = COLS - 1;
                    end
                    shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, CH_NUL};
                end
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    shadow_screen[i] = {shadow_attr, BLANK_CHAR};
                shadow_col = 0;
                shadow_row = 0;
                clears++;
            end
            default:
            begin
                if (req.read_row < LINES && req.read_col < COLS)
                begin
                    read_cell = shadow_screen[req.read_row * COLS + req.read_col];
                    res.cell_char = read_cell[7:0];
                    res.cell_attr = read_cell[15:8];
                    reads_in_range++;
                end
            end
        endcase
        res.cursor_col = 7'(shadow_col);
        res.cursor_row = 5'(shadow_row);
        return res;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        int pick;
        req.action    = ACT_CHAR;
        req.char_code = 8'($urandom_range(255));
        req.read_row  = 5'($urandom_range(31));
        req.read_col  = 7'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            pick = $urandom_range(99);
            if (pick < 7)
                req.char_code = CH_LF;
            else if (pick < 12)
                req.char_code = CH_CR;
            else if (pick < 17)
                req.char_code = CH_TAB;
            else if (pick < 20)
                req.char_code = CH_VT;
        end
        else if (pick < 70)
            req.action = ACT_BACKSPACE;
        else if (pick < 72)
            req.action = ACT_CLEAR;
        else
        begin
            req.action = ACT_READ;
            pick = $urandom_range(99);
            // Mostly read inside the screen, often on the line being written.
            if (pick < 40)
            begin
                req.read_row = 5'(shadow_row);
                req.read_col = 7'($urandom_range(COLS - 1));
            end
            else if (pick < 85)
            begin
                req.read_row = 5'($urandom_range(LINES - 1));
                req.read_col = 7'($urandom_range(COLS - 1));
            end
        end
        return req;
    endfunction

    task automatic push_request(input in_item_t req, input bit typed, input out_item_t want);
        out_item_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        got = console_apply(req);
        cursor_reports.push_back(typed ? want : got);
        requests_sent++;
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_attr = value;
        attr_writes++;
    endtask

    task automatic wait_drained();
        while (cursor_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin : report_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (cursor_reports.size() == 0)
            begin
                $display("%0t: report with no request waiting, actual %p", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = cursor_reports.pop_front();
                compare_field("cursor_col", 8'(want.cursor_col), 8'(out_data.cursor_col));
                compare_field("cursor_row", 8'(want.cursor_row), 8'(out_data.cursor_row));
                compare_field("cell_char", want.cell_char, out_data.cell_char);
                compare_field("cell_attr", want.cell_attr, out_data.cell_attr);
            end
        end
    end

    initial
    begin
        #(100_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int send_plan [4];
        int stall_plan [4];
        logic [7:0] attr_plan [4];
        send_plan  = '{0, 72, 0, 33};
        stall_plan = '{0, 0, 72, 33};
        attr_plan  = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};

        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = {RESET_ATTR, BLANK_CHAR};
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = RESET_ATTR;

        // Requests fed right after reset with the reset attribute.
        script[0]  = '{'{ACT_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{7'd0, 5'd0, BLANK_CHAR, RESET_ATTR}};
        script[1]  = '{'{ACT_READ, 8'h00, 5'd24, 7'd79}, 1'b1,
                       '{7'd0, 5'd0, BLANK_CHAR, RESET_ATTR}};
        script[2]  = '{'{ACT_READ, 8'h00, 5'd25, 7'd0}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00}};
        script[3]  = '{'{ACT_READ, 8'hFF, 5'd31, 7'd127}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00}};
        script[4]  = '{'{ACT_BACKSPACE, 8'h00, 5'd0, 7'd0}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00}};
        script[5]  = '{'{ACT_CHAR, 8'h41, 5'd0, 7'd0}, 1'b1, '{7'd1, 5'd0, 8'h00, 8'h00}};
        script[6]  = '{'{ACT_CHAR, 8'hFF, 5'd0, 7'd0}, 1'b1, '{7'd2, 5'd0, 8'h00, 8'h00}};
        script[7]  = '{'{ACT_CHAR, CH_NUL, 5'd0, 7'd0}, 1'b1, '{7'd3, 5'd0, 8'h00, 8'h00}};
        script[8]  = '{'{ACT_CHAR, CH_TAB, 5'd0, 7'd0}, 1'b1, '{7'd4, 5'd0, 8'h00, 8'h00}};
        script[9]  = '{'{ACT_READ, 8'h00, 5'd0, 7'd1}, 1'b1, '{7'd4, 5'd0, 8'hFF, RESET_ATTR}};
        script[10] = '{'{ACT_CHAR, CH_CR, 5'd0, 7'd0}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00}};
        script[11] = '{'{ACT_CHAR, CH_LF, 5'd0, 7'd0}, 1'b1, '{7'd0, 5'd1, 8'h00, 8'h00}};
        script[12] = '{'{ACT_BACKSPACE, 8'h00, 5'd0, 7'd0}, 1'b1, '{7'd79, 5'd0, 8'h00, 8'h00}};
        script[13] = '{'{ACT_CHAR, 8'h7A, 5'd0, 7'd0}, 1'b1, '{7'd0, 5'd1, 8'h00, 8'h00}};
        // Vertical tabs down to the last line; the last two overshoot and scroll once each.
        for (int k = 14; k < 23; k++)
            script[k] = '{'{ACT_CHAR, CH_VT, 5'd0, 7'd0}, 1'b0, '0};
        script[23] = '{'{ACT_READ, 8'h00, 5'd24, 7'd0}, 1'b0, '0};
        script[24] = '{'{ACT_CLEAR, 8'h00, 5'd0, 7'd0}, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00}};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < SCRIPT_LEN; k++)
            push_request(script[k].req, script[k].typed, script[k].want);
        in_valid <= 1'b0;

        for (int p = 0; p < 4; p++)
        begin
            // Hold off new requests until every report is back, then retune.
            wait_drained();
            write_attribute(attr_plan[p]);
            send_idle_pct  = send_plan[p];
            recv_stall_pct = stall_plan[p];
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_request(random_request(), 1'b0, '0);
            in_valid <= 1'b0;
        end

        wait_drained();
        $display("Sent %0d requests and checked %0d reports under four idle/stall mixes.",
                 requests_sent, results_seen);
        $display("Seen %0d scrolls, %0d clears, %0d in-range reads, %0d attribute writes.",
                 scrolls, clears, reads_in_range, attr_writes);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
